// ----- hw/rtl/aoq_pkg.sv -----
// Shared codes and types for the two-class age-ordered queue.
package aoq_pkg;

    // Sideband widths on the stream ports.
    localparam int S_TUSER_W = 3;
    localparam int M_TUSER_W = 1;

    // Command codes carried in the input word.
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Dequeue target codes.
    localparam logic [1:0] PICK_OLDEST = 2'd0;
    localparam logic [1:0] PICK_A      = 2'd1;
    localparam logic [1:0] PICK_B      = 2'd2;
    localparam logic [1:0] PICK_NONE   = 2'd3;

    // Result status codes.
    localparam logic STAT_DEQ  = 1'b0;
    localparam logic STAT_DROP = 1'b1;

    // Command sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } seq_state_t;

    // Occupancy flags of one class queue.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- hw/rtl/aoq_class_queue.sv -----
// One class queue: stamp and value memory with head, tail and fill count.
module aoq_class_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int STAMP_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [STAMP_WIDTH-1:0] push_stamp,
    input  logic [VALUE_WIDTH-1:0] push_value,
    input  logic                   pop,
    output logic [STAMP_WIDTH-1:0] head_stamp,
    output logic [VALUE_WIDTH-1:0] head_value,
    output aoq_pkg::q_status_t     status
);
    import aoq_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = STAMP_WIDTH + VALUE_WIDTH;

    logic [ENTRY_W-1:0] store_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Entry write at the tail on push and registered read at the head, every cycle.
    always_ff @(posedge aclk) begin
        if (push) begin
            store_mem[tail_reg] <= {push_stamp, push_value};
        end
        rd_data_reg <= store_mem[head_reg];
    end

    assign head_stamp = rd_data_reg[ENTRY_W-1:VALUE_WIDTH];
    assign head_value = rd_data_reg[VALUE_WIDTH-1:0];

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Pointer wrap at the queue depth, which need not be a power of two.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/two_class_age_ordered_queue.sv -----
// Top level: two class queues sharing an arrival stamp, with oldest-first or per-class dequeue.
// An accepted enqueue that fits gives no word; one per cycle is sustained while no dequeue or drop evaluates.
// A dequeue or a dropped enqueue moves the sequencer to its evaluate state, with the input not ready:
// its word is loaded into the output register from there, later while the output word is stalled.
// Synchronous active-low reset clears pointers, counts, stamp and output valid;
// the entry memories are not cleared.
module two_class_age_ordered_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int STAMP_WIDTH = 16,
    localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [TDATA_WIDTH-1:0]           s_tdata,  // item_value
    input  logic [aoq_pkg::S_TUSER_W-1:0]    s_tuser,  // cmd, pick[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [TDATA_WIDTH-1:0]           m_tdata,  // out_value
    output logic [aoq_pkg::M_TUSER_W-1:0]    m_tuser   // status
);
    import aoq_pkg::*;

    seq_state_t               state_reg, state_next;
    logic                     drop_reg;
    logic [1:0]               pick_reg;
    logic [STAMP_WIDTH-1:0]   stamp_reg;
    logic                     m_tvalid_reg;
    logic [TDATA_WIDTH-1:0]   m_tdata_reg;
    logic [M_TUSER_W-1:0]     m_tuser_reg;

    logic                     s_accept;
    logic                     in_cmd;
    logic [1:0]               in_pick;
    logic [VALUE_WIDTH-1:0]   in_value;
    logic                     in_neg;
    logic                     push_a, push_b, drop_in, deq_in;
    logic                     pop_a, pop_b;
    logic [STAMP_WIDTH-1:0]   a_stamp, b_stamp, stamp_diff;
    logic [VALUE_WIDTH-1:0]   a_value, b_value;
    q_status_t                a_st, b_st;
    logic                     older_b, take_a, take_b;
    logic                     need_out, out_free, finish, out_load;

    // Input word decode.
    assign s_accept = s_tvalid && s_tready;
    assign in_cmd   = s_tuser[0];
    assign in_pick  = s_tuser[2:1];
    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_neg   = in_value[VALUE_WIDTH-1];

    assign push_a  = s_accept && (in_cmd == CMD_ENQ) && !in_neg && !a_st.full;
    assign push_b  = s_accept && (in_cmd == CMD_ENQ) && in_neg && !b_st.full;
    assign drop_in = s_accept && (in_cmd == CMD_ENQ) && (in_neg ? b_st.full : a_st.full);
    assign deq_in  = s_accept && (in_cmd == CMD_DEQ);

    aoq_class_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_queue_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_a),
        .push_stamp (stamp_reg),
        .push_value (in_value),
        .pop        (pop_a),
        .head_stamp (a_stamp),
        .head_value (a_value),
        .status     (a_st)
    );

    aoq_class_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_queue_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_b),
        .push_stamp (stamp_reg),
        .push_value (in_value),
        .pop        (pop_b),
        .head_stamp (b_stamp),
        .head_value (b_value),
        .status     (b_st)
    );

    // Class B is older when the modular stamp difference is positive and nonzero.
    assign stamp_diff = a_stamp - b_stamp;
    assign older_b    = (stamp_diff != '0) && !stamp_diff[STAMP_WIDTH-1];

    // Dequeue target selection from the latched pick.
    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (!drop_reg) begin
            case (pick_reg)
                PICK_OLDEST: begin
                    take_a = !a_st.empty && (b_st.empty || !older_b);
                    take_b = !b_st.empty && (a_st.empty || older_b);
                end
                PICK_A:  take_a = !a_st.empty;
                PICK_B:  take_b = !b_st.empty;
                default: begin
                    take_a = 1'b0;
                    take_b = 1'b0;
                end
            endcase
        end
    end

    // The evaluate step waits only if it has a word and the output is still full.
    assign need_out = drop_reg || take_a || take_b;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_EVAL) && (!need_out || out_free);
    assign out_load = finish && need_out;
    assign pop_a    = finish && take_a;
    assign pop_b    = finish && take_b;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: enqueues that fit finish at once, everything else evaluates.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (deq_in || drop_in) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            drop_reg  <= 1'b0;
            stamp_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                drop_reg <= drop_in;
            end
            if (push_a || push_b) begin
                stamp_reg <= stamp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pick_reg <= in_pick;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (drop_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= STAT_DROP;
            end else begin
                m_tdata_reg <= TDATA_WIDTH'(take_a ? a_value : b_value);
                m_tuser_reg <= STAT_DEQ;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/aoq_checker.sv -----
// Port-level checks for the two-class age-ordered queue, bound to the top level.
module aoq_checker #(
    parameter int DATA_W = 32
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [aoq_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [DATA_W-1:0]              m_tdata,
    input logic [aoq_pkg::M_TUSER_W-1:0]  m_tuser
);
    import aoq_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A dropped enqueue reports a zero value.
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == STAT_DROP) |-> m_tdata == '0)
        else $error("drop word carries nonzero data");

    // A dequeue holds off the input while it evaluates.
    a_deq_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_DEQ) |=> !s_tready)
        else $error("input accepted during dequeue evaluation");

    // Reset leaves the block ready with no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind two_class_age_ordered_queue aoq_checker #(
    .DATA_W (TDATA_WIDTH)
) u_aoq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
